@@ hdl/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement - shared types
// Sequencer states, request token and update broadcast passed along the
// row of frame cells.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // Wide enough for frame numbers and ranks of up to 64 frames
  localparam int unsigned SLOT_W = 6;
  // Widest page number the store supports
  localparam int unsigned PAGE_W = 32;
  // Width and reset value of the frames_in_use register
  localparam int unsigned FIU_W = 5;
  localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [PAGE_W-1:0] page_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_COMMIT
  } lrupr_state_e;

  // Partial search result handed from cell to cell
  typedef struct packed {
    logic  valid;
    logic  hit;
    slot_t hit_slot;
    slot_t hit_rank;
    logic  empty;
    slot_t empty_slot;
    slot_t lru_slot;
    slot_t lru_rank;
    page_t lru_page;
  } tok_t;

  // Recency and placement update broadcast to every cell
  typedef struct packed {
    logic  valid;
    logic  load;
    logic  was_valid;
    slot_t slot;
    slot_t old_rank;
  } upd_t;

endpackage

@@ hdl/lrupr_if.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement - channel interfaces
// Request channel carrying a page reference, response channel carrying the
// lookup outcome and running totals.
// ----------------------------------------------------------------------------
interface lrupr_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  frame_index;
  logic        evicted_valid;
  logic [15:0] evicted_page;
  logic [31:0] hit_total;
  logic [31:0] miss_total;

  modport source (
    output valid, output hit, output frame_index, output evicted_valid,
    output evicted_page, output hit_total, output miss_total, input ready
  );
  modport sink (
    input valid, input hit, input frame_index, input evicted_valid,
    input evicted_page, input hit_total, input miss_total, output ready
  );
endinterface

@@ hdl/lrupr_cell.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement - frame cell
// Holds one frame (page, occupancy, recency rank). Folds its frame into the
// search token and passes it on one cell per cycle; applies the broadcast
// update to its own rank and contents.
// ----------------------------------------------------------------------------
module lrupr_cell import lrupr_pkg::*; #(
  parameter int unsigned CELL_IDX  = 0,
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned RANK_W    = 4,
  parameter int unsigned ACT_W     = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  input  page_t            page_i,
  input  logic [ACT_W-1:0] active_i,
  input  upd_t             upd_i
);

  localparam slot_t ME = slot_t'(CELL_IDX);

  logic                 valid_q;
  logic [RANK_W-1:0]    rank_q;
  logic [PAGE_BITS-1:0] page_q;
  tok_t                 tok_q;
  tok_t                 tok_d;
  logic                 act;

  assign act = ACT_W'(CELL_IDX) < active_i;

  always_comb begin
    tok_d = tok_i;
    if (act && valid_q && !tok_i.hit && (page_q == page_i[PAGE_BITS-1:0])) begin
      tok_d.hit      = 1'b1;
      tok_d.hit_slot = ME;
      tok_d.hit_rank = slot_t'(rank_q);
    end
    if (act && !valid_q && !tok_i.empty) begin
      tok_d.empty      = 1'b1;
      tok_d.empty_slot = ME;
    end
    // first cell seeds the oldest-frame search
    if (act && ((CELL_IDX == 0) || (rank_q > tok_i.lru_rank[RANK_W-1:0]))) begin
      tok_d.lru_slot = ME;
      tok_d.lru_rank = slot_t'(rank_q);
      tok_d.lru_page = page_t'(page_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i.valid) begin
      if (upd_i.slot == ME) begin
        valid_q <= 1'b1;
        rank_q  <= '0;
      end else if (valid_q &&
                   (!upd_i.was_valid || (rank_q < upd_i.old_rank[RANK_W-1:0]))) begin
        // age frames that were more recent than the touched one, or every valid frame when an empty one is filled
        rank_q <= rank_q + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.valid && upd_i.load && (upd_i.slot == ME)) begin
      page_q <= page_i[PAGE_BITS-1:0];
    end
  end

endmodule

@@ hdl/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement - top level
// Fully associative page store with least-recently-used replacement, built
// as a row of frame cells walked by a search token.
// ----------------------------------------------------------------------------
// One request at a time: the search token visits the frame cells in turn,
//   then the decision is registered and the update committed, and the
//   sequencer returns to idle before the next request is taken.
// A finished response waits in the output register while the next request
//   is taken.
// Reset: all frames empty, counters zero, frames_in_use 16; no clearing pass.
module lru_page_replacement import lrupr_pkg::*; #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [FIU_W-1:0] cfg_wdata_i,
  lrupr_req_if.sink        req,
  lrupr_rsp_if.source      rsp
);

  localparam int unsigned RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned ACT_W  = $clog2(FRAMES + 1);
  localparam page_t PAGE_MASK = page_t'((64'd1 << PAGE_BITS) - 64'd1);

  lrupr_state_e st_q, st_d;

  logic [FIU_W-1:0] fiu_q;
  page_t            page_q;
  logic [ACT_W-1:0] active_q, active_d;
  tok_t             dec_q;
  logic [31:0]      hit_cnt_q, miss_cnt_q, hit_cnt_d, miss_cnt_d;

  logic        rsp_valid_q;
  logic        rsp_hit_q;
  logic [3:0]  rsp_frame_q;
  logic        rsp_ev_valid_q;
  logic [15:0] rsp_ev_page_q;
  logic [31:0] rsp_hit_total_q, rsp_miss_total_q;

  logic  accept, launch, commit, out_free;
  tok_t  chain [FRAMES+1];
  upd_t  upd;
  slot_t slot;
  logic  evict;
  page_t ev_page;
  logic [31:0] slot_ext;
  logic [7:0]  fiu_ext;

  // ---- sequencer ----
  assign out_free = !rsp_valid_q || rsp.ready;
  assign accept   = req.valid && req.ready;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (req.valid) st_d = ST_LAUNCH;
      ST_LAUNCH: st_d = ST_SCAN;
      ST_SCAN:   if (chain[FRAMES].valid) st_d = ST_COMMIT;
      ST_COMMIT: if (out_free) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    launch    = 1'b0;
    commit    = 1'b0;
    unique case (st_q)
      ST_IDLE:   req.ready = 1'b1;
      ST_LAUNCH: launch = 1'b1;
      ST_SCAN:   ;
      ST_COMMIT: commit = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      fiu_q <= FIU_RESET;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        fiu_q <= cfg_wdata_i;
      end
    end
  end

  // ---- clamp the active frame count ----
  always_comb begin
    fiu_ext = 8'(fiu_q);
    priority if (fiu_ext == 8'd0) begin
      active_d = ACT_W'(1);
    end else if (fiu_ext > 8'(FRAMES)) begin
      active_d = ACT_W'(FRAMES);
    end else begin
      active_d = fiu_ext[ACT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q   <= page_t'(req.page_number) & PAGE_MASK;
      active_q <= active_d;
    end
    if (chain[FRAMES].valid) begin
      dec_q <= chain[FRAMES];
    end
  end

  // ---- cell row ----
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
  end

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    lrupr_cell #(
      .CELL_IDX (k),
      .PAGE_BITS(PAGE_BITS),
      .RANK_W   (RANK_W),
      .ACT_W    (ACT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (chain[k]),
      .tok_o   (chain[k+1]),
      .page_i  (page_q),
      .active_i(active_q),
      .upd_i   (upd)
    );
  end

  // ---- decision ----
  always_comb begin
    evict = !dec_q.hit && !dec_q.empty;
    priority if (dec_q.hit) begin
      slot = dec_q.hit_slot;
    end else if (dec_q.empty) begin
      slot = dec_q.empty_slot;
    end else begin
      slot = dec_q.lru_slot;
    end
    ev_page       = evict ? dec_q.lru_page : '0;
    upd.valid     = commit;
    upd.load      = !dec_q.hit;
    upd.was_valid = dec_q.hit || !dec_q.empty;
    upd.slot      = slot;
    upd.old_rank  = dec_q.hit ? dec_q.hit_rank : dec_q.lru_rank;
    slot_ext      = 32'(slot);
  end

  // Saturating running totals
  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (dec_q.hit) begin
      if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + 32'd1;
    end else begin
      if (miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_hit_q        <= dec_q.hit;
      rsp_frame_q      <= slot_ext[3:0];
      rsp_ev_valid_q   <= evict;
      rsp_ev_page_q    <= ev_page[15:0];
      rsp_hit_total_q  <= hit_cnt_d;
      rsp_miss_total_q <= miss_cnt_d;
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.hit           = rsp_hit_q;
  assign rsp.frame_index   = rsp_frame_q;
  assign rsp.evicted_valid = rsp_ev_valid_q;
  assign rsp.evicted_page  = rsp_ev_page_q;
  assign rsp.hit_total     = rsp_hit_total_q;
  assign rsp.miss_total    = rsp_miss_total_q;

endmodule

@@ hdl/lrupr_checker.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement - port checker
// Watches the top-level channels for ordering, stall and result consistency.
// ----------------------------------------------------------------------------
module lrupr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_hit_i,
  input logic [3:0]  rsp_frame_index_i,
  input logic        rsp_evicted_valid_i,
  input logic [15:0] rsp_evicted_page_i,
  input logic [31:0] rsp_hit_total_i,
  input logic [31:0] rsp_miss_total_i
);

  logic [31:0] last_hit_q, last_miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hit_q  <= '0;
      last_miss_q <= '0;
    end else if (rsp_valid_i && rsp_ready_i) begin
      last_hit_q  <= rsp_hit_total_i;
      last_miss_q <= rsp_miss_total_i;
    end
  end

  // One request at a time: ready drops after every accepted request
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in progress");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_hit_i |-> !rsp_evicted_valid_i)
    else $error("eviction reported on a hit");

  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_evicted_valid_i |-> rsp_evicted_page_i == 16'd0)
    else $error("evicted page not zero without eviction");

  a_totals_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_hit_total_i >= last_hit_q) && (rsp_miss_total_i >= last_miss_q))
    else $error("running totals went backwards");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_frame_index_i)
      && $stable(rsp_hit_i) && $stable(rsp_hit_total_i) && $stable(rsp_miss_total_i))
    else $error("stalled response changed");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req.valid),
  .req_ready_i        (req.ready),
  .rsp_valid_i        (rsp.valid),
  .rsp_ready_i        (rsp.ready),
  .rsp_hit_i          (rsp.hit),
  .rsp_frame_index_i  (rsp.frame_index),
  .rsp_evicted_valid_i(rsp.evicted_valid),
  .rsp_evicted_page_i (rsp.evicted_page),
  .rsp_hit_total_i    (rsp.hit_total),
  .rsp_miss_total_i   (rsp.miss_total)
);
